### hdl/double_ended_queue_macros.svh
// Assertion macros shared by the double-ended queue modules.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef SYNTH
`define DQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### hdl/dq_pkg.sv
// Types and codes shared by the double-ended queue modules.
package dq_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_COUNT      = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_POPPED = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_COUNT  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic    ins_head;
    logic    ins_tail;
    logic    rem_head;
    logic    rem_tail;
    logic    load_resp;
    logic    resp_from_ram;
    status_e resp_status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } sts_t;

endpackage

### hdl/double_ended_queue.sv
// Top level of the double-ended queue of signed 32-bit words.
// A count, empty-pop or full-push result is valid in the cycle after its transaction;
// a pop result passes the store's registered read, then the result register; a
// successful push gives no result. Throughput: one transaction per cycle, except that
// a held result stalls input, and a pop holds off the next one while its read completes.
// Reset clears the pointers, the count and the result valid; the store is not cleared.
module double_ended_queue #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 req_type_i,
  input  logic signed [31:0]         push_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic signed [31:0]         popped_value_o,
  output logic [$clog2(DEPTH+1)-1:0] entry_count_o
);

  import dq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .push_value_i   (push_value_i),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

### hdl/dq_ram.sv
// Generic single-port RAM with a registered read.
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/dq_dpath.sv
// Datapath: ring pointers, word count, word store and result register.
`include "double_ended_queue_macros.svh"

module dq_dpath #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dq_pkg::cmd_t                 cmd_i,
  output dq_pkg::sts_t                 sts_o,
  input  logic signed [31:0]           push_value_i,
  output logic [1:0]                   status_o,
  output logic signed [31:0]           popped_value_o,
  output logic [$clog2(DEPTH+1)-1:0]   entry_count_o
);

  import dq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic [IdxW-1:0] head_prev, head_next, tail_prev, tail_next;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] ram_addr;
  logic            ram_we, ram_re;
  logic [31:0]     ram_rdata;

  status_e            status_q;
  logic signed [31:0] value_q;
  logic [CntW-1:0]    count_out_q;

  assign head_prev = (head_q == '0) ? LastIdx : head_q - IdxW'(1);
  assign head_next = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
  assign tail_prev = (tail_q == '0) ? LastIdx : tail_q - IdxW'(1);
  assign tail_next = (tail_q == LastIdx) ? '0 : tail_q + IdxW'(1);

  assign sts_o.empty = (cnt_q == '0);
  assign sts_o.full  = (cnt_q == FullCnt);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    ram_addr = tail_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    if (cmd_i.ins_head) begin
      head_d   = head_prev;
      ram_addr = head_prev;
      ram_we   = 1'b1;
      cnt_d    = cnt_q + CntW'(1);
    end else if (cmd_i.ins_tail) begin
      tail_d   = tail_next;
      ram_addr = tail_q;
      ram_we   = 1'b1;
      cnt_d    = cnt_q + CntW'(1);
    end else if (cmd_i.rem_head) begin
      head_d   = head_next;
      ram_addr = head_q;
      ram_re   = 1'b1;
      cnt_d    = cnt_q - CntW'(1);
    end else if (cmd_i.rem_tail) begin
      tail_d   = tail_prev;
      ram_addr = tail_prev;
      ram_re   = 1'b1;
      cnt_d    = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_resp) begin
      status_q    <= cmd_i.resp_status;
      value_q     <= cmd_i.resp_from_ram ? $signed(ram_rdata) : '0;
      count_out_q <= cnt_q;
    end
  end

  dq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (push_value_i),
    .rdata_o (ram_rdata)
  );

  assign status_o       = status_q;
  assign popped_value_o = value_q;
  assign entry_count_o  = count_out_q;

  `DQ_ASSERT_IMPL(a_cnt_in_range, clk_i, rst_ni, 1'b1, cnt_q <= FullCnt,
    "Word count exceeds depth")
  `DQ_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, cmd_i.rem_head || cmd_i.rem_tail,
    !sts_o.empty, "Pop issued on an empty store")
  `DQ_ASSERT_NEXT(a_push_counts, clk_i, rst_ni, cmd_i.ins_head || cmd_i.ins_tail,
    cnt_q == $past(cnt_q) + CntW'(1), "Push did not raise the count")

endmodule

### hdl/dq_ctrl.sv
// Controller: handshake, request decode and pop read sequencing.
`include "double_ended_queue_macros.svh"

module dq_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [2:0]   req_type_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  dq_pkg::sts_t sts_i,
  output dq_pkg::cmd_t cmd_o
);

  import dq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_held;
  logic   accept;

  assign out_held   = out_valid_q && out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || out_held;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o       = '0;
    cmd_o.resp_status = ST_COUNT;
    state_d     = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              if (sts_i.full) begin
                cmd_o.load_resp   = 1'b1;
                cmd_o.resp_status = ST_FULL;
              end else begin
                cmd_o.ins_head = (req_type_i == REQ_PUSH_FRONT);
                cmd_o.ins_tail = (req_type_i == REQ_PUSH_BACK);
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (sts_i.empty) begin
                cmd_o.load_resp   = 1'b1;
                cmd_o.resp_status = ST_EMPTY;
              end else begin
                cmd_o.rem_head = (req_type_i == REQ_POP_FRONT);
                cmd_o.rem_tail = (req_type_i == REQ_POP_BACK);
                state_d        = S_READ;
              end
            end
            REQ_COUNT: begin
              cmd_o.load_resp   = 1'b1;
              cmd_o.resp_status = ST_COUNT;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.load_resp     = 1'b1;
        cmd_o.resp_from_ram = 1'b1;
        cmd_o.resp_status   = ST_POPPED;
        state_d             = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_resp) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `DQ_ASSERT_IMPL(a_read_out_free, clk_i, rst_ni, state_q == S_READ, !out_valid_q,
    "Result register busy during a pop read")
  `DQ_ASSERT_NEXT(a_read_one_cycle, clk_i, rst_ni, state_q == S_READ, state_q == S_IDLE,
    "Pop read lasted more than one cycle")
  `DQ_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd_o.load_resp, !out_held,
    "Held result overwritten")

endmodule
